// ----- hdl/tspnf_pkg.sv -----
// Shared types and constants for the particle slot pool with next-fit allocation.
// No dependencies; the design files refer to this package by scoped names, the bench imports it.
package tspnf_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 64;
  localparam int unsigned SLOT_W         = 6;
  localparam int unsigned LIFE_W         = 16;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 16;

  // 1.0 in unsigned Q1.15
  localparam logic [LIFE_W-1:0] LIFE_FULL = 16'h8000;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_TICK = 2'd1,
    OP_SCAN = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_LIVE  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECAY_RATE = 2'd0,
    REG_TEXTURE_ID = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic        [15:0] ext;
    logic        [31:0] col;
  } payload_t;

  localparam int unsigned PAYLOAD_W = $bits(payload_t);

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    payload_t          pl;
    logic [15:0]       texture;
    logic              last;
  } result_t;

endpackage

// ----- hdl/tspnf_if.sv -----
// Channel interfaces for the particle slot pool: input word, result word, register write.
// Depends on tspnf_pkg for widths.
interface tspnf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic [15:0]        extent;
  logic [31:0]        rgba;
  logic [15:0]        time_step;

  modport source (output valid, opcode, pos_x, pos_y, vel_x, vel_y, extent, rgba, time_step,
                  input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, vel_x, vel_y, extent, rgba, time_step,
                  output ready);
endinterface

interface tspnf_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [tspnf_pkg::SLOT_W-1:0]  slot;
  logic signed [15:0]            out_x;
  logic signed [15:0]            out_y;
  logic signed [15:0]            out_vx;
  logic signed [15:0]            out_vy;
  logic [15:0]                   out_extent;
  logic [31:0]                   out_rgba;
  logic [15:0]                   out_texture;
  logic                          last;

  modport source (output valid, kind, slot, out_x, out_y, out_vx, out_vy, out_extent,
                  out_rgba, out_texture, last, input ready);
  modport sink   (input valid, kind, slot, out_x, out_y, out_vx, out_vy, out_extent,
                  out_rgba, out_texture, last, output ready);
endinterface

interface tspnf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tspnf_pkg::CFG_IDX_W-1:0]  index;
  logic [tspnf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/tspnf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on tspnf_pkg for default sizes.
module tspnf_ram #(
  parameter int unsigned WIDTH = tspnf_pkg::LIFE_W,
  parameter int unsigned DEPTH = tspnf_pkg::SLOT_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/ttl_slot_pool_next_fit_core.sv -----
// Top level of the particle slot pool: next-fit allocation, life decay tick, live scan.
// Depends on tspnf_pkg, the interfaces in tspnf_if.sv and tspnf_ram.
//
//  channel  | dir | handshake    | word
//  ---------+-----+--------------+------------------------------------------------
//  in_ch    | in  | valid/ready  | opcode, position, velocity, extent, rgba, time_step
//  out_ch   | out | valid/ready  | kind, slot, particle fields, texture, last
//  cfg_ch   | in  | valid/ready  | register index, 16-bit data (ready always high)
//
// Operation: one word at a time. Add, tick and scan each sweep the life store once through
// its single read port, one slot a cycle unless a scan holds its sweep; add stops early at
// the first free slot. A no-op word is taken without leaving idle.
// Reset: synchronous, active low; clears the slot valid bits (every slot free), the search
// start, both registers and all handshake state. No clearing pass is needed.
// Stalls: the result register lets a new word in while a result still waits. A scan holds
// its sweep while two live slots are pending behind a stalled result register.
module ttl_slot_pool_next_fit_core #(
  parameter int unsigned SLOT_COUNT = tspnf_pkg::SLOT_COUNT_DEF
) (
  input logic         clk,
  input logic         rst_n,
  tspnf_in_if.sink    in_ch,
  tspnf_out_if.source out_ch,
  tspnf_cfg_if.sink   cfg_ch
);

  localparam int unsigned AW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(SLOT_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SRCH,
    ST_ADD_WR,
    ST_TICK,
    ST_SCAN,
    ST_SCAN_END
  } state_t;

  // control state
  state_t                    state_r, state_nxt;
  logic [15:0]               decay_rate_r, decay_rate_nxt;
  logic [15:0]               texture_id_r, texture_id_nxt;
  logic [AW-1:0]             search_start_r, search_start_nxt;
  logic [SLOT_COUNT-1:0]     valid_r, valid_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]             rd_idx_r, rd_idx_nxt;
  logic                      pend_vld_r, pend_vld_nxt;
  logic                      out_vld_r, out_vld_nxt;
  tspnf_pkg::result_t        out_res_r, out_res_nxt;

  // datapath registers
  logic [15:0]               dec_r, dec_nxt;
  tspnf_pkg::payload_t       add_pl_r, add_pl_nxt;
  logic [AW-1:0]             chosen_r, chosen_nxt;
  tspnf_pkg::result_t        pend_r, pend_nxt;

  // memory ports
  logic                      life_we, pl_we, mem_re;
  logic [AW-1:0]             life_waddr, mem_raddr;
  logic [tspnf_pkg::LIFE_W-1:0] life_wdata, life_rd;
  tspnf_pkg::payload_t       pl_rd;
  logic [tspnf_pkg::PAYLOAD_W-1:0] pl_rd_raw;

  logic                      in_acc, cfg_acc, out_free, step, issue, live;
  logic [tspnf_pkg::LIFE_W-1:0] life_eff;
  logic [31:0]               prod;
  logic [tspnf_pkg::SLOT_W-1:0] rd_slot;

  // Life store; an entry whose valid bit is clear reads as zero (free)
  tspnf_ram #(
    .WIDTH (tspnf_pkg::LIFE_W),
    .DEPTH (SLOT_COUNT)
  ) u_life_ram (
    .clk   (clk),
    .we    (life_we),
    .waddr (life_waddr),
    .wdata (life_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (life_rd)
  );

  // Particle fields, written only by add at the same time as the life entry
  tspnf_ram #(
    .WIDTH (tspnf_pkg::PAYLOAD_W),
    .DEPTH (SLOT_COUNT)
  ) u_pl_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (chosen_r),
    .wdata (add_pl_r),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (pl_rd_raw)
  );

  assign pl_rd    = tspnf_pkg::payload_t'(pl_rd_raw);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  assign out_free = !out_vld_r || out_ch.ready;
  assign life_eff = valid_r[rd_idx_r] ? life_rd : '0;
  assign live     = (life_eff != '0);
  assign prod     = 32'(decay_rate_r) * 32'(in_ch.time_step);
  assign rd_slot  = tspnf_pkg::SLOT_W'(rd_idx_r);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_vld_r;
  assign out_ch.kind        = out_res_r.kind;
  assign out_ch.slot        = out_res_r.slot;
  assign out_ch.out_x       = out_res_r.pl.x;
  assign out_ch.out_y       = out_res_r.pl.y;
  assign out_ch.out_vx      = out_res_r.pl.vx;
  assign out_ch.out_vy      = out_res_r.pl.vy;
  assign out_ch.out_extent  = out_res_r.pl.ext;
  assign out_ch.out_rgba    = out_res_r.pl.col;
  assign out_ch.out_texture = out_res_r.texture;
  assign out_ch.last        = out_res_r.last;

  // The sweep: one read issued per advancing cycle; the data returns next cycle.
  // Tick writes slot a while reading slot a+1, so read and write never meet.
  always_comb begin
    state_nxt        = state_r;
    decay_rate_nxt   = decay_rate_r;
    texture_id_nxt   = texture_id_r;
    search_start_nxt = search_start_r;
    valid_nxt        = valid_r;
    idx_nxt          = idx_r;
    cnt_nxt          = cnt_r;
    rd_vld_nxt       = rd_vld_r;
    rd_idx_nxt       = rd_idx_r;
    pend_vld_nxt     = pend_vld_r;
    out_vld_nxt      = out_vld_r && !out_ch.ready;
    out_res_nxt      = out_res_r;
    dec_nxt          = dec_r;
    add_pl_nxt       = add_pl_r;
    chosen_nxt       = chosen_r;
    pend_nxt         = pend_r;
    life_we          = 1'b0;
    life_waddr       = rd_idx_r;
    life_wdata       = tspnf_pkg::LIFE_FULL;
    pl_we            = 1'b0;
    mem_re           = 1'b0;
    mem_raddr        = idx_r;
    step             = 1'b1;
    issue            = 1'b0;

    if (cfg_acc) begin
      case (cfg_ch.index)
        tspnf_pkg::REG_DECAY_RATE: decay_rate_nxt = cfg_ch.data;
        tspnf_pkg::REG_TEXTURE_ID: texture_id_nxt = cfg_ch.data;
        default: ;
      endcase
    end

    // a scan holds while a second live slot waits and the result register is blocked
    if (state_r == ST_SCAN) begin
      step = !(rd_vld_r && live && pend_vld_r && !out_free);
    end

    if (state_r == ST_ADD_SRCH || state_r == ST_TICK || state_r == ST_SCAN) begin
      issue = step && (cnt_r != CNT_FULL);
      if (issue) begin
        mem_re     = 1'b1;
        idx_nxt    = (idx_r == LAST_IDX) ? '0 : idx_r + AW'(1);
        cnt_nxt    = cnt_r + CW'(1);
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = idx_r;
      end else if (step) begin
        rd_vld_nxt = 1'b0;
      end
    end

    case (state_r)
      ST_IDLE: begin
        rd_vld_nxt = 1'b0;
        if (in_acc) begin
          idx_nxt = '0;
          cnt_nxt = '0;
          case (in_ch.opcode)
            tspnf_pkg::OP_ADD: begin
              add_pl_nxt.x   = in_ch.pos_x;
              add_pl_nxt.y   = in_ch.pos_y;
              add_pl_nxt.vx  = in_ch.vel_x;
              add_pl_nxt.vy  = in_ch.vel_y;
              add_pl_nxt.ext = in_ch.extent;
              add_pl_nxt.col = in_ch.rgba;
              idx_nxt        = search_start_r;
              chosen_nxt     = '0;
              state_nxt      = ST_ADD_SRCH;
            end
            tspnf_pkg::OP_TICK: begin
              dec_nxt   = prod[31:16];
              state_nxt = ST_TICK;
            end
            tspnf_pkg::OP_SCAN: begin
              pend_vld_nxt = 1'b0;
              state_nxt    = ST_SCAN;
            end
            default: ;
          endcase
        end
      end

      ST_ADD_SRCH: begin
        if (rd_vld_r && !live) begin
          chosen_nxt       = rd_idx_r;
          search_start_nxt = rd_idx_r;
          rd_vld_nxt       = 1'b0;
          state_nxt        = ST_ADD_WR;
        end else if (rd_vld_r && cnt_r == CNT_FULL) begin
          // pool full: overwrite slot 0, search start unchanged
          rd_vld_nxt = 1'b0;
          state_nxt  = ST_ADD_WR;
        end
      end

      ST_ADD_WR: begin
        if (out_free) begin
          life_we                = 1'b1;
          life_waddr             = chosen_r;
          life_wdata             = tspnf_pkg::LIFE_FULL;
          pl_we                  = 1'b1;
          valid_nxt[chosen_r]    = 1'b1;
          out_vld_nxt            = 1'b1;
          out_res_nxt.kind       = tspnf_pkg::KIND_ALLOC;
          out_res_nxt.slot       = tspnf_pkg::SLOT_W'(chosen_r);
          out_res_nxt.pl         = add_pl_r;
          out_res_nxt.texture    = texture_id_r;
          out_res_nxt.last       = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end

      ST_TICK: begin
        if (rd_vld_r && live) begin
          life_we    = 1'b1;
          life_waddr = rd_idx_r;
          life_wdata = (life_rd > dec_r) ? life_rd - dec_r : '0;
        end
        if (cnt_r == CNT_FULL && !rd_vld_r) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // each live slot is held back one step so that the last one can be marked
        if (rd_vld_r && live && step) begin
          if (pend_vld_r) begin
            out_vld_nxt      = 1'b1;
            out_res_nxt      = pend_r;
            out_res_nxt.last = 1'b0;
          end
          pend_vld_nxt     = 1'b1;
          pend_nxt.kind    = tspnf_pkg::KIND_LIVE;
          pend_nxt.slot    = rd_slot;
          pend_nxt.pl      = pl_rd;
          pend_nxt.texture = texture_id_r;
          pend_nxt.last    = 1'b0;
        end
        if (cnt_r == CNT_FULL && !rd_vld_r) begin
          state_nxt = ST_SCAN_END;
        end
      end

      ST_SCAN_END: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          if (pend_vld_r) begin
            out_res_nxt = pend_r;
          end else begin
            out_res_nxt.kind    = tspnf_pkg::KIND_EMPTY;
            out_res_nxt.slot    = '0;
            out_res_nxt.pl      = '0;
            out_res_nxt.texture = texture_id_r;
          end
          out_res_nxt.last = 1'b1;
          pend_vld_nxt     = 1'b0;
          state_nxt        = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      decay_rate_r   <= '0;
      texture_id_r   <= '0;
      search_start_r <= '0;
      valid_r        <= '0;
      idx_r          <= '0;
      cnt_r          <= '0;
      rd_vld_r       <= 1'b0;
      rd_idx_r       <= '0;
      pend_vld_r     <= 1'b0;
      out_vld_r      <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      decay_rate_r   <= decay_rate_nxt;
      texture_id_r   <= texture_id_nxt;
      search_start_r <= search_start_nxt;
      valid_r        <= valid_nxt;
      idx_r          <= idx_nxt;
      cnt_r          <= cnt_nxt;
      rd_vld_r       <= rd_vld_nxt;
      rd_idx_r       <= rd_idx_nxt;
      pend_vld_r     <= pend_vld_nxt;
      out_vld_r      <= out_vld_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    dec_r    <= dec_nxt;
    add_pl_r <= add_pl_nxt;
    chosen_r <= chosen_nxt;
    pend_r   <= pend_nxt;
  end

endmodule

// ----- hdl/tspnf_chk.sv -----
// Port-level checker for the particle slot pool, bound to the top level.
// Depends on tspnf_pkg and ttl_slot_pool_next_fit_core.
module tspnf_chk #(
  parameter int unsigned SLOT_COUNT = tspnf_pkg::SLOT_COUNT_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [1:0]                   in_opcode,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_kind,
  input logic [tspnf_pkg::SLOT_W-1:0] out_slot,
  input logic                         out_last
);

  // a result word stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // every real operation leaves the block busy once its word is taken
  a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode != tspnf_pkg::OP_NOP |=> !in_ready)
    else $error("new word taken while an operation is running");

  // allocation and empty-scan results are single words
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == tspnf_pkg::KIND_ALLOC || out_kind == tspnf_pkg::KIND_EMPTY)
    |-> out_last)
    else $error("single-word result without last");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_slot) < SLOT_COUNT) &&
                  (out_kind != tspnf_pkg::KIND_EMPTY || out_slot == '0))
    else $error("slot index out of range");

endmodule

bind ttl_slot_pool_next_fit_core tspnf_chk #(.SLOT_COUNT(SLOT_COUNT)) u_tspnf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_slot  (out_ch.slot),
  .out_last  (out_ch.last)
);

// ----- tb/sv/ttl_slot_pool_next_fit_core_test.sv -----
// Self-checking bench for ttl_slot_pool_next_fit_core: adds, ticks and scans on the particle pool.
// Drives the block through the tspnf_if channels and predicts each result word from its own
// copy of the pool; depends on tspnf_pkg, tspnf_if.sv and the core.
module ttl_slot_pool_next_fit_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tspnf_pkg::*;

  localparam int unsigned SLOTS        = SLOT_COUNT_DEF;
  // a tick or a no-op gives no word back, so leave a full sweep before touching registers
  localparam int unsigned QUIET_CYCLES = SLOTS + 16;
  localparam int unsigned IDLE_PCT     = 18;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned MAX_PRINTS   = 60;

  // one input word as the sender sees it
  typedef struct packed {
    op_t         op;
    payload_t    pl;
    logic [15:0] dt;
  } particle_word_t;

  logic clk;
  logic rst_n;

  tspnf_in_if  in_ch ();
  tspnf_out_if out_ch ();
  tspnf_cfg_if cfg_ch ();

  ttl_slot_pool_next_fit_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Pool prediction: life per slot, payload per slot, next-fit origin, registers
  // ---------------------------------------------------------------------------
  logic [LIFE_W-1:0] pool_life [SLOTS];
  payload_t          pool_payload [SLOTS];
  logic [SLOT_W-1:0] fit_origin;
  logic [15:0]       decay_rate_q;
  logic [15:0]       texture_q;

  particle_word_t pending_words[$];    // words still to be offered
  result_t        expected_reports[$]; // result words predicted but not yet seen

  int unsigned fail_count;
  int unsigned report_seq;

  // stimulus controls, written only by the sequencing initial block
  bit          no_idle;
  int unsigned hold_req;

  // handshake bookkeeping: word_taken is shared between monitor and driver, the hold counters belong to the receiver
  bit          word_taken;
  int unsigned hold_seen;
  int unsigned hold_left;

  function automatic void predict_pool_word(particle_word_t w);
    int unsigned       k;
    int unsigned       idx;
    logic              found;
    logic [SLOT_W-1:0] pick;
    logic [31:0]       dec;
    int unsigned       final_live;
    result_t           rep;
    rep = '0;
    rep.texture = texture_q;
    case (w.op)
      OP_ADD: begin
        // next-fit: from the last pick upwards, wrapping; a full pool loses slot 0
        found = 1'b0;
        pick  = '0;
        for (k = 0; k < SLOTS; k++) begin
          idx = (int'(fit_origin) + k) % SLOTS;
          if (!found && pool_life[idx] == '0) begin
            found = 1'b1;
            pick  = SLOT_W'(idx);
          end
        end
        if (found) fit_origin = pick;
        pool_payload[pick] = w.pl;
        pool_life[pick]    = LIFE_FULL;
        rep.kind = KIND_ALLOC;
        rep.slot = pick;
        rep.pl   = w.pl;
        rep.last = 1'b1;
        expected_reports.push_back(rep);
      end
      OP_TICK: begin
        dec = (32'(decay_rate_q) * 32'(w.dt)) >> 16;
        for (k = 0; k < SLOTS; k++) begin
          if (pool_life[k] != '0)
            pool_life[k] = (32'(pool_life[k]) > dec) ? pool_life[k] - dec[15:0] : '0;
        end
      end
      OP_SCAN: begin
        found      = 1'b0;
        final_live = 0;
        for (k = 0; k < SLOTS; k++) begin
          if (pool_life[k] != '0) begin
            found      = 1'b1;
            final_live = k;
          end
        end
        if (!found) begin
          rep.kind = KIND_EMPTY;
          rep.last = 1'b1;
          expected_reports.push_back(rep);
        end else begin
          for (k = 0; k < SLOTS; k++) begin
            if (pool_life[k] != '0) begin
              rep.kind = KIND_LIVE;
              rep.slot = SLOT_W'(k);
              rep.pl   = pool_payload[k];
              rep.last = (k == final_live);
              expected_reports.push_back(rep);
            end
          end
        end
      end
      default: ; // no-op word: nothing changes
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("%0t ns result word %0d: %s got %h expected %h",
               $realtime, report_seq, what, got_v, want_v);
  endtask

  task automatic compare_report(result_t got, result_t want);
    if (got.kind !== want.kind)       note_mismatch("kind", got.kind, want.kind);
    if (got.slot !== want.slot)       note_mismatch("slot", got.slot, want.slot);
    if (got.pl.x !== want.pl.x)       note_mismatch("x", got.pl.x, want.pl.x);
    if (got.pl.y !== want.pl.y)       note_mismatch("y", got.pl.y, want.pl.y);
    if (got.pl.vx !== want.pl.vx)     note_mismatch("vx", got.pl.vx, want.pl.vx);
    if (got.pl.vy !== want.pl.vy)     note_mismatch("vy", got.pl.vy, want.pl.vy);
    if (got.pl.ext !== want.pl.ext)   note_mismatch("extent", got.pl.ext, want.pl.ext);
    if (got.pl.col !== want.pl.col)   note_mismatch("rgba", got.pl.col, want.pl.col);
    if (got.texture !== want.texture) note_mismatch("texture", got.texture, want.texture);
    if (got.last !== want.last)       note_mismatch("last", got.last, want.last);
  endtask

  // Monitor: at each rising edge, predict from an accepted input word and register
  // write first, then check any result word leaving the block.
  always @(posedge clk) begin : monitor_p
    particle_word_t w;
    result_t        got;
    if (!rst_n) begin
      word_taken = 1'b0;
    end else begin
      word_taken = in_ch.valid && in_ch.ready;
      if (word_taken) begin
        w.op     = op_t'(in_ch.opcode);
        w.pl.x   = in_ch.pos_x;
        w.pl.y   = in_ch.pos_y;
        w.pl.vx  = in_ch.vel_x;
        w.pl.vy  = in_ch.vel_y;
        w.pl.ext = in_ch.extent;
        w.pl.col = in_ch.rgba;
        w.dt     = in_ch.time_step;
        predict_pool_word(w);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_DECAY_RATE: decay_rate_q = cfg_ch.data;
          REG_TEXTURE_ID: texture_q    = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.kind    = kind_t'(out_ch.kind);
        got.slot    = out_ch.slot;
        got.pl.x    = out_ch.out_x;
        got.pl.y    = out_ch.out_y;
        got.pl.vx   = out_ch.out_vx;
        got.pl.vy   = out_ch.out_vy;
        got.pl.ext  = out_ch.out_extent;
        got.pl.col  = out_ch.out_rgba;
        got.texture = out_ch.out_texture;
        got.last    = out_ch.last;
        if (expected_reports.size() == 0)
          note_mismatch("unexpected word, slot", got.slot, '0);
        else
          compare_report(got, expected_reports.pop_front());
        report_seq++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver, both on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver_p
    particle_word_t nxt;
    logic           offer;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || word_taken) begin
      // a word on the bus stays until taken; only then may a gap start
      offer = pending_words.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT);
      if (offer) begin
        nxt = pending_words.pop_front();
        in_ch.opcode    <= nxt.op;
        in_ch.pos_x     <= nxt.pl.x;
        in_ch.pos_y     <= nxt.pl.y;
        in_ch.vel_x     <= nxt.pl.vx;
        in_ch.vel_y     <= nxt.pl.vy;
        in_ch.extent    <= nxt.pl.ext;
        in_ch.rgba      <= nxt.pl.col;
        in_ch.time_step <= nxt.dt;
        in_ch.valid     <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off each time one is requested
  always @(negedge clk) begin : sink_p
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // unused fields get random content too: the block must ignore them
  function automatic particle_word_t any_word(op_t op);
    particle_word_t w;
    w.op     = op;
    w.pl.x   = 16'($urandom);
    w.pl.y   = 16'($urandom);
    w.pl.vx  = 16'($urandom);
    w.pl.vy  = 16'($urandom);
    w.pl.ext = 16'($urandom);
    w.pl.col = $urandom;
    w.dt     = 16'($urandom);
    return w;
  endfunction

  function automatic particle_word_t tick_of(logic [15:0] dt);
    particle_word_t w;
    w    = any_word(OP_TICK);
    w.dt = dt;
    return w;
  endfunction

  // short time steps let lives run down over several ticks instead of one
  function automatic particle_word_t mixed_word(int unsigned add_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < add_pct)
      return any_word(OP_ADD);
    if (roll < add_pct + 22)
      return ($urandom_range(3) != 0) ? tick_of(16'($urandom_range(4095))) : any_word(OP_TICK);
    if (roll < 95)
      return any_word(OP_SCAN);
    return any_word(OP_NOP);
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // pause the sender until every word is in and every predicted result word has left
  task automatic settle_pool();
    do @(posedge clk); while (pending_words.size() != 0 || in_ch.valid);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin : sequence_p
    particle_word_t w;
    int unsigned    n;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_NOP;
    in_ch.pos_x      = '0;
    in_ch.pos_y      = '0;
    in_ch.vel_x      = '0;
    in_ch.vel_y      = '0;
    in_ch.extent     = '0;
    in_ch.rgba       = '0;
    in_ch.time_step  = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_DECAY_RATE;
    cfg_ch.data      = '0;
    no_idle          = 1'b0;
    hold_req         = 0;
    hold_seen        = 0;
    hold_left        = 0;
    fail_count       = 0;
    report_seq       = 0;
    fit_origin       = '0;
    decay_rate_q     = '0;
    texture_q        = '0;
    for (n = 0; n < SLOTS; n++) pool_life[n] = '0;

    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // registers at reset values: empty scan, tick on an empty pool, no-op, extreme payloads
    pending_words.push_back(any_word(OP_SCAN));
    pending_words.push_back(tick_of(16'hFFFF));
    pending_words.push_back(any_word(OP_NOP));
    w = any_word(OP_ADD);
    w.pl = {16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'h0000, 32'h0000_0000};
    pending_words.push_back(w);
    w = any_word(OP_ADD);
    w.pl = {16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0000, 16'hFFFF, 32'hFFFF_FFFF};
    pending_words.push_back(w);
    pending_words.push_back(any_word(OP_ADD));
    pending_words.push_back(any_word(OP_SCAN));
    pending_words.push_back(tick_of(16'hFFFF));   // zero decay: nothing ages
    pending_words.push_back(any_word(OP_SCAN));
    settle_pool();

    // fastest decay: a unit step takes nothing, a full step clears the pool
    write_reg(REG_DECAY_RATE, 16'hFFFF);
    write_reg(REG_TEXTURE_ID, 16'hFFFF);
    pending_words.push_back(tick_of(16'h0001));
    pending_words.push_back(any_word(OP_SCAN));
    pending_words.push_back(tick_of(16'hFFFF));
    pending_words.push_back(any_word(OP_SCAN));
    pending_words.push_back(any_word(OP_ADD));    // search resumes from the last pick
    pending_words.push_back(any_word(OP_ADD));
    pending_words.push_back(any_word(OP_SCAN));
    settle_pool();

    // half decay at half a second: two ticks land exactly on zero
    write_reg(REG_DECAY_RATE, 16'h8000);
    write_reg(REG_TEXTURE_ID, 16'($urandom));
    pending_words.push_back(any_word(OP_ADD));
    pending_words.push_back(tick_of(16'h8000));
    pending_words.push_back(any_word(OP_SCAN));
    pending_words.push_back(tick_of(16'h8000));
    pending_words.push_back(any_word(OP_SCAN));
    settle_pool();

    // no decay: fill the pool past full so slot 0 is overwritten; the receiver holds
    // off meanwhile so the block backs up and stalls its input
    write_reg(REG_DECAY_RATE, 16'h0000);
    write_reg(REG_TEXTURE_ID, 16'h0000);
    for (n = 0; n < SLOTS + 2; n++) pending_words.push_back(any_word(OP_ADD));
    hold_req++;
    pending_words.push_back(any_word(OP_SCAN));
    pending_words.push_back(any_word(OP_ADD));
    pending_words.push_back(any_word(OP_SCAN));
    settle_pool();

    // fastest decay again, mostly short steps so lives run down gradually
    write_reg(REG_DECAY_RATE, 16'hFFFF);
    write_reg(REG_TEXTURE_ID, 16'($urandom));
    for (n = 0; n < 60; n++) pending_words.push_back(mixed_word(40));
    settle_pool();

    // mid decay with neither side idling for the whole phase
    write_reg(REG_DECAY_RATE, 16'($urandom_range(2000, 40000)));
    write_reg(REG_TEXTURE_ID, 16'($urandom));
    no_idle = 1'b1;
    for (n = 0; n < 100; n++) pending_words.push_back(mixed_word(45));
    settle_pool();
    no_idle = 1'b0;

    // slow decay, add-heavy so scans run long; a second hold-off lands among them
    write_reg(REG_DECAY_RATE, 16'($urandom_range(1, 4000)));
    write_reg(REG_TEXTURE_ID, 16'($urandom));
    for (n = 0; n < 100; n++) pending_words.push_back(mixed_word(55));
    repeat (200) @(posedge clk);
    hold_req++;

    // wind down: bounded wait for the last result words, then a quiet spell
    do @(posedge clk); while (pending_words.size() != 0 || in_ch.valid);
    for (n = 0; n < 20000 && expected_reports.size() != 0; n++) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0)
      note_mismatch("result words never produced, count", expected_reports.size(), '0);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin : watchdog_p
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
